>>> sv/bmma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block MAC package
// Operation codes, queue sizes and the result side-band type shared by the
// front end, the back end and the result queue.
// ----------------------------------------------------------------------------
package bmma_pkg;

   localparam int OP_W        = 3;
   localparam int POS_W       = 3;
   localparam int CFG_W       = 4;
   localparam int CFG_RESET   = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_A = 3'd0,
      OP_LOAD_B = 3'd1,
      OP_MAC    = 3'd2,
      OP_READ   = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } rsp_meta_type;

endpackage

>>> sv/bmma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block MAC channel interfaces
// Request channel carrying commands and load words, response channel
// carrying C elements of a read-out run.
// ----------------------------------------------------------------------------
interface bmma_req_if #(
   parameter int DATA_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   operation;
   logic [2:0]                   row;
   logic [2:0]                   col;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, operation, row, col, value, input ready);
   modport sink   (input valid, operation, row, col, value, output ready);
endinterface

interface bmma_rsp_if #(
   parameter int ACC_WIDTH = 48
);
   logic                        valid;
   logic                        ready;
   logic [2:0]                  out_row;
   logic [2:0]                  out_col;
   logic signed [ACC_WIDTH-1:0] out_value;
   logic                        last;

   modport source (output valid, out_row, out_col, out_value, last, input ready);
   modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

>>> sv/bmma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block MAC front end
// Accepts request words, drops unknown codes and out-of-range loads, and
// queues the rest as commands for the back end.
// ----------------------------------------------------------------------------
module bmma_front #(
   parameter int  MAX_BLOCK  = 8,
   parameter int  DATA_WIDTH = 16,
   localparam int CELLS      = MAX_BLOCK * MAX_BLOCK,
   localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   bmma_req_if.sink                     req,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output bmma_pkg::op_type             cmd_kind,
   output logic [AW-1:0]                cmd_addr,
   output logic signed [DATA_WIDTH-1:0] cmd_value
);
   import bmma_pkg::*;

   op_type                       q_kind_ff  [QUEUE_DEPTH];
   logic [AW-1:0]                q_addr_ff  [QUEUE_DEPTH];
   logic signed [DATA_WIDTH-1:0] q_value_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]           cnt_ff, cnt_in;

   op_type        op;
   logic          in_range;
   logic          keep;
   logic          push;
   logic          pop;
   logic [AW-1:0] addr;

   assign op       = op_type'(req.operation);
   assign in_range = (int'(req.row) < MAX_BLOCK) && (int'(req.col) < MAX_BLOCK);
   assign addr     = AW'(int'(req.row) * MAX_BLOCK + int'(req.col));

   always_comb begin
      case (op)
         OP_LOAD_A, OP_LOAD_B:      keep = in_range;
         OP_MAC, OP_READ, OP_CLEAR: keep = 1'b1;
         default:                   keep = 1'b0;
      endcase
   end

   assign req.ready = (int'(cnt_ff) != QUEUE_DEPTH);
   assign push      = req.valid && req.ready && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;

   assign cmd_kind  = q_kind_ff[rd_ptr_ff];
   assign cmd_addr  = q_addr_ff[rd_ptr_ff];
   assign cmd_value = q_value_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_kind_ff[wr_ptr_ff]  <= op;
         q_addr_ff[wr_ptr_ff]  <= addr;
         q_value_ff[wr_ptr_ff] <= req.value;
      end
   end

endmodule

>>> sv/bmma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block MAC back end
// Holds the A, B and C stores, runs the pipelined multiply-accumulate pass
// and issues the row-major read-out of C towards the result queue.
// ----------------------------------------------------------------------------
module bmma_back #(
   parameter int  MAX_BLOCK  = 8,
   parameter int  DATA_WIDTH = 16,
   parameter int  ACC_WIDTH  = 48,
   localparam int CELLS      = MAX_BLOCK * MAX_BLOCK,
   localparam int AW         = (CELLS > 1) ? $clog2(CELLS) : 1,
   localparam int IW         = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [IW-1:0]                    n_m1,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  bmma_pkg::op_type                 cmd_kind,
   input  logic [AW-1:0]                    cmd_addr,
   input  logic signed [DATA_WIDTH-1:0]     cmd_value,
   input  logic [bmma_pkg::OUT_CNT_W-1:0]   rsp_level,
   output logic                             push,
   output bmma_pkg::rsp_meta_type           push_meta,
   output logic signed [ACC_WIDTH-1:0]      push_value
);
   import bmma_pkg::*;

   localparam int PW = 2 * DATA_WIDTH;
   localparam int SW = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;
   localparam logic signed [SW-1:0] ACC_HI =
      signed'((SW'(1) << (ACC_WIDTH - 1)) - SW'(1));
   localparam logic signed [SW-1:0] ACC_LO = -ACC_HI - SW'(1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   logic signed [DATA_WIDTH-1:0] a_mem [CELLS];
   logic signed [DATA_WIDTH-1:0] b_mem [CELLS];
   logic signed [ACC_WIDTH-1:0]  c_mem [CELLS];
   logic [CELLS-1:0]             c_valid_ff;

   state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic signed [DATA_WIDTH-1:0] a_rd_ff, b_rd_ff;
   logic signed [ACC_WIDTH-1:0]  c_rd_ff;
   logic                         cv_ff;

   logic          s1_vld_ff, s1_first_ff, s1_last_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s2_vld_ff, s2_first_ff, s2_last_ff;
   logic [AW-1:0] s2_addr_ff;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic signed [ACC_WIDTH-1:0] s2_c_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [ACC_WIDTH-1:0] base;
   logic signed [SW-1:0]        sum;

   logic         ro_vld_ff;
   rsp_meta_type ro_meta_ff;

   logic          pop, issue_mac, issue_rd, credit;
   logic          end_i, end_j, end_k, c_we;
   logic [AW-1:0] a_raddr, b_raddr, c_raddr;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign pop       = cmd_valid && cmd_ready;
   assign credit    = (int'(rsp_level) + int'(ro_vld_ff)) < OUT_DEPTH;
   assign issue_mac = (state_ff == ST_MAC);
   assign issue_rd  = (state_ff == ST_READ) && credit;

   assign end_i = (i_ff == n_m1);
   assign end_j = (j_ff == n_m1);
   assign end_k = (k_ff == n_m1);

   assign a_raddr = AW'(int'(i_ff) * MAX_BLOCK + int'(k_ff));
   assign b_raddr = AW'(int'(k_ff) * MAX_BLOCK + int'(j_ff));
   assign c_raddr = AW'(int'(i_ff) * MAX_BLOCK + int'(j_ff));

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (pop) begin
               case (cmd_kind)
                  OP_MAC:  state_in = ST_MAC;
                  OP_READ: state_in = ST_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MAC: begin
            k_in = end_k ? '0 : k_ff + 1'b1;
            if (end_k) begin
               j_in = end_j ? '0 : j_ff + 1'b1;
            end
            if (end_k && end_j) begin
               i_in = end_i ? '0 : i_ff + 1'b1;
            end
            if (end_k && end_j && end_i) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (issue_rd) begin
               j_in = end_j ? '0 : j_ff + 1'b1;
               if (end_j) begin
                  i_in = end_i ? '0 : i_ff + 1'b1;
               end
               if (end_j && end_i) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign prod_in = PW'(a_rd_ff) * PW'(b_rd_ff);
   assign base    = s2_first_ff ? s2_c_ff : acc_ff;
   assign sum     = SW'(base) + SW'(prod_ff);

   always_comb begin
      if (sum > ACC_HI) begin
         acc_in = ACC_WIDTH'(ACC_HI);
      end else if (sum < ACC_LO) begin
         acc_in = ACC_WIDTH'(ACC_LO);
      end else begin
         acc_in = ACC_WIDTH'(sum);
      end
   end

   assign c_we       = s2_vld_ff && s2_last_ff;
   assign push       = ro_vld_ff;
   assign push_meta  = ro_meta_ff;
   assign push_value = cv_ff ? c_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         ro_vld_ff  <= 1'b0;
         c_valid_ff <= '0;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         s1_vld_ff <= issue_mac;
         s2_vld_ff <= s1_vld_ff;
         ro_vld_ff <= issue_rd;
         if (pop && (cmd_kind == OP_CLEAR)) begin
            c_valid_ff <= '0;
         end else if (c_we) begin
            c_valid_ff[s2_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && (cmd_kind == OP_LOAD_A)) begin
         a_mem[cmd_addr] <= cmd_value;
      end
      if (pop && (cmd_kind == OP_LOAD_B)) begin
         b_mem[cmd_addr] <= cmd_value;
      end
      if (c_we) begin
         c_mem[s2_addr_ff] <= acc_in;
      end
      a_rd_ff <= a_mem[a_raddr];
      b_rd_ff <= b_mem[b_raddr];
      c_rd_ff <= c_mem[c_raddr];
      cv_ff   <= c_valid_ff[c_raddr];
   end

   always_ff @(posedge clock) begin
      s1_first_ff     <= (k_ff == '0);
      s1_last_ff      <= end_k;
      s1_addr_ff      <= c_raddr;
      s2_first_ff     <= s1_first_ff;
      s2_last_ff      <= s1_last_ff;
      s2_addr_ff      <= s1_addr_ff;
      s2_c_ff         <= cv_ff ? c_rd_ff : '0;
      prod_ff         <= prod_in;
      ro_meta_ff.row  <= POS_W'(i_ff);
      ro_meta_ff.col  <= POS_W'(j_ff);
      ro_meta_ff.last <= end_i && end_j;
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("accumulate pipeline busy while idle");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (int'(rsp_level) < OUT_DEPTH))
      else $error("result queue overflow");

   a_pass_drains: assert property (@(posedge clock) disable iff (reset)
      (issue_mac && end_i && end_j && end_k) |=> (state_ff == ST_DRAIN))
      else $error("accumulate pass did not drain");

   a_read_origin: assert property (@(posedge clock) disable iff (reset)
      ro_vld_ff |-> $past(state_ff == ST_READ))
      else $error("read-out word outside a read run");
`endif

endmodule

>>> sv/bmma_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block MAC result queue
// Short queue between the C read port and the response channel; reports its
// fill level so the back end only issues reads that have room.
// ----------------------------------------------------------------------------
module bmma_rsp_fifo #(
   parameter int ACC_WIDTH = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  bmma_pkg::rsp_meta_type         push_meta,
   input  logic signed [ACC_WIDTH-1:0]    push_value,
   output logic [bmma_pkg::OUT_CNT_W-1:0] level,
   bmma_rsp_if.source                     rsp
);
   import bmma_pkg::*;

   rsp_meta_type                meta_ff  [OUT_DEPTH];
   logic signed [ACC_WIDTH-1:0] value_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                        pop;

   assign level         = cnt_ff;
   assign rsp.valid     = (cnt_ff != '0);
   assign pop           = rsp.valid && rsp.ready;
   assign rsp.out_row   = meta_ff[rd_ptr_ff].row;
   assign rsp.out_col   = meta_ff[rd_ptr_ff].col;
   assign rsp.last      = meta_ff[rd_ptr_ff].last;
   assign rsp.out_value = value_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == OUT_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == OUT_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         meta_ff[wr_ptr_ff]  <= push_meta;
         value_ff[wr_ptr_ff] <= push_value;
      end
   end

endmodule

>>> sv/block_matrix_multiply_accumulate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block matrix multiply-accumulate
// C += A x B over square blocks of the configured size; load, accumulate,
// read-out and clear commands arrive as request words.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_     in   valid/ready   operation, row, col, value
//  rsp_     out  valid/ready   out_row, out_col, out_value, last
//  csr_     in   wr_en         wr_data (block dimension)
//
//  Loads and clear leave the back end idle, ready for the next command; the
//  command queue lets the front accept a word every cycle while it has room.
//  Accumulate occupies the back end for the MAC pass and pipeline drain
//  (one shared multiplier, one adder). Read-out sends n*n words through
//  the single C read port, one per cycle while the result queue has room.
//  Reset marks all of C zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_matrix_multiply_accumulate_top #(
   parameter int MAX_BLOCK  = 8,
   parameter int DATA_WIDTH = 16,
   parameter int ACC_WIDTH  = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   bmma_req_if.sink                    req_chan,
   bmma_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [bmma_pkg::CFG_W-1:0]  csr_wr_data
);
   import bmma_pkg::*;

   localparam int CELLS = MAX_BLOCK * MAX_BLOCK;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int IW    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

   logic [CFG_W-1:0]             dim_cfg_ff;
   logic [IW-1:0]                n_m1;
   logic                         cmd_valid, cmd_ready;
   op_type                       cmd_kind;
   logic [AW-1:0]                cmd_addr;
   logic signed [DATA_WIDTH-1:0] cmd_value;
   logic [OUT_CNT_W-1:0]         rsp_level;
   logic                         push;
   rsp_meta_type                 push_meta;
   logic signed [ACC_WIDTH-1:0]  push_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_cfg_ff <= CFG_W'(CFG_RESET);
      end else if (csr_wr_en) begin
         dim_cfg_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (dim_cfg_ff == '0) begin
         n_m1 = '0;
      end else if (int'(dim_cfg_ff) > MAX_BLOCK) begin
         n_m1 = IW'(MAX_BLOCK - 1);
      end else begin
         n_m1 = IW'(dim_cfg_ff - 1'b1);
      end
   end

   bmma_front #(
      .MAX_BLOCK  (MAX_BLOCK),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_kind  (cmd_kind),
      .cmd_addr  (cmd_addr),
      .cmd_value (cmd_value)
   );

   bmma_back #(
      .MAX_BLOCK  (MAX_BLOCK),
      .DATA_WIDTH (DATA_WIDTH),
      .ACC_WIDTH  (ACC_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .n_m1       (n_m1),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd_kind   (cmd_kind),
      .cmd_addr   (cmd_addr),
      .cmd_value  (cmd_value),
      .rsp_level  (rsp_level),
      .push       (push),
      .push_meta  (push_meta),
      .push_value (push_value)
   );

   bmma_rsp_fifo #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_meta  (push_meta),
      .push_value (push_value),
      .level      (rsp_level),
      .rsp        (rsp_chan)
   );

endmodule
